// ===== rtl/serial_switch_command_parser_assert.svh =====
// Assertion macros for the serial switch command parser.
// Each macro samples on clk and is disabled while rst is high.
`ifndef SERIAL_SWITCH_COMMAND_PARSER_ASSERT_SVH
`define SERIAL_SWITCH_COMMAND_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define SSCP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sscp assertion failed");
`define SSCP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sscp assertion failed");
`else
`define SSCP_ASSERT_IMP(label, ante, cons)
`define SSCP_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/sscp_pkg.sv =====
`default_nettype none
package sscp_pkg;

  localparam int LINE_CAP = 32;
  localparam int IDX_W    = $clog2(LINE_CAP);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_V     = 8'h56;

  typedef enum logic [1:0] {
    REPLY_OK  = 2'd0,
    REPLY_ERR = 2'd1,
    REPLY_VER = 2'd2
  } reply_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_C0,
    PH_VE,
    PH_VR,
    PH_VEND,
    PH_O1,
    PH_OF2,
    PH_WS,
    PH_DIG
  } phase_t;

endpackage
`default_nettype wire

// ===== rtl/serial_switch_command_parser.sv =====
// Serial switch command parser.
// Slave stream s_axis carries one received byte per transaction. Bytes other
// than CR or LF are stored in the line buffer; when the buffer already holds
// LINE_CAP-1 bytes the next such byte empties it and gives no reply. A CR or
// LF starts a scan of the buffer, one stored byte at a time, each read in
// ST_FETCH through the buffer's single registered read port and judged in
// ST_EVAL by a small character sequencer, and yields exactly one reply
// transaction on master stream m_axis. s_axis_tready is low during the scan.
// The reply sits in an output register; a new byte is taken while it waits.
// If a second reply is ready while the first is still stalled, the scan
// holds its result until m_axis_tready takes the first one.
// Reset empties the line and drops any pending reply; buffer contents past
// the fill count are never read, so the buffer itself needs no clearing.
`default_nettype none
`include "serial_switch_command_parser_assert.svh"
module serial_switch_command_parser
  import sscp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [1:0] reply_code, [2] drive_valid,
                                          // [4:3] switch_number, [5] switch_level
);

  logic [7:0]       line_mem [LINE_CAP];
  logic [7:0]       rd_data;
  logic [IDX_W-1:0] fill_count;
  logic [IDX_W-1:0] idx;

  state_t state, state_next;
  phase_t phase, phase_next;

  logic       neg, neg_next;
  logic [2:0] val, val_next;
  logic       level, level_next;

  logic [7:0] ch;
  logic       ch_ws, ch_digit, ch_sign;
  logic [5:0] acc;
  logic [2:0] acc_sat;
  logic       eval_done, num_done;
  reply_t     eval_code;
  logic [1:0] eval_sw;

  reply_t     pend_code;
  logic [1:0] pend_sw;
  logic       pend_level;

  reply_t     out_code;
  logic       out_drive;
  logic [1:0] out_sw;
  logic       out_level;

  logic in_fire, is_term, out_free;

  assign s_axis_tready = !rst && (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_term       = (s_axis_tdata == CH_CR) || (s_axis_tdata == CH_LF);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (in_fire && !is_term && fill_count < IDX_W'(LINE_CAP - 1)) begin
      line_mem[fill_count] <= s_axis_tdata;
    end
    rd_data <= line_mem[idx];
  end

  assign ch       = (idx < fill_count) ? rd_data : CH_NUL;
  assign ch_ws    = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
  assign ch_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign ch_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign acc      = (6'(val) * 6'd10) + 6'(ch - CH_ZERO);
  assign acc_sat  = (acc > 6'd3) ? 3'd4 : acc[2:0];

  always_comb begin
    eval_done  = 1'b0;
    num_done   = 1'b0;
    eval_code  = REPLY_ERR;
    eval_sw    = 2'd0;
    phase_next = phase;
    neg_next   = neg;
    val_next   = val;
    level_next = level;
    unique case (phase)
      PH_C0: begin
        if (ch == CH_V) phase_next = PH_VE;
        else if (ch == CH_O) phase_next = PH_O1;
        else eval_done = 1'b1;
      end
      PH_VE: begin
        if (ch == CH_E) phase_next = PH_VR;
        else eval_done = 1'b1;
      end
      PH_VR: begin
        if (ch == CH_R) phase_next = PH_VEND;
        else eval_done = 1'b1;
      end
      PH_VEND: begin
        eval_done = 1'b1;
        if (ch == CH_NUL) eval_code = REPLY_VER;
      end
      PH_O1: begin
        if (ch == CH_N) begin
          level_next = 1'b1;
          phase_next = PH_WS;
        end else if (ch == CH_F) begin
          phase_next = PH_OF2;
        end else begin
          eval_done = 1'b1;
        end
      end
      PH_OF2: begin
        if (ch == CH_F) begin
          level_next = 1'b0;
          phase_next = PH_WS;
        end else begin
          eval_done = 1'b1;
        end
      end
      PH_WS: begin
        priority if (ch_ws) begin
          phase_next = PH_WS;
        end else if (ch_sign) begin
          neg_next   = (ch == CH_MINUS);
          phase_next = PH_DIG;
        end else if (ch_digit) begin
          val_next   = acc_sat;
          phase_next = PH_DIG;
        end else begin
          num_done = 1'b1;
        end
      end
      PH_DIG: begin
        if (ch_digit) val_next = acc_sat;
        else num_done = 1'b1;
      end
      default: eval_done = 1'b1;
    endcase
    if (num_done) begin
      eval_done = 1'b1;
      if (!neg && val != 3'd0 && val <= 3'd3) begin
        eval_code = REPLY_OK;
        eval_sw   = val[1:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_fire && is_term) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_EVAL;
      ST_EVAL:  state_next = eval_done ? ST_DONE : ST_FETCH;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fill_count    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire && !is_term) begin
        if (fill_count < IDX_W'(LINE_CAP - 1)) fill_count <= fill_count + 1'b1;
        else fill_count <= '0;
      end
      if (state == ST_DONE && out_free) begin
        fill_count    <= '0;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        idx   <= '0;
        phase <= PH_C0;
        neg   <= 1'b0;
        val   <= 3'd0;
        level <= 1'b0;
      end
      ST_EVAL: begin
        phase <= phase_next;
        neg   <= neg_next;
        val   <= val_next;
        level <= level_next;
        if (eval_done) begin
          pend_code  <= eval_code;
          pend_sw    <= eval_sw;
          pend_level <= level_next && (eval_sw != 2'd0);
        end else begin
          idx <= idx + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_code  <= pend_code;
          out_drive <= (pend_sw != 2'd0);
          out_sw    <= pend_sw;
          out_level <= pend_level;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {2'b00, out_level, out_sw, out_drive, out_code};

  `SSCP_ASSERT_IMP(a_fill_bound, 1'b1, fill_count <= IDX_W'(LINE_CAP - 1))
  `SSCP_ASSERT_IMP(a_scan_bound, state == ST_EVAL, idx <= fill_count)
  `SSCP_ASSERT_IMP(a_drive_ok, m_axis_tvalid,
    (out_drive == (out_code == REPLY_OK)) && (out_drive == (out_sw != 2'd0)))
  `SSCP_ASSERT_NXT(a_term_scan, in_fire && is_term, state == ST_FETCH)
  `SSCP_ASSERT_NXT(a_reply_clear, state == ST_DONE && out_free,
    m_axis_tvalid && fill_count == '0 && state == ST_IDLE)

endmodule
`default_nettype wire

// ===== tb/sv/serial_switch_command_parser_tb.sv =====
`timescale 1ns / 100ps
module serial_switch_command_parser_tb;
  import sscp_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [1:0] reply_code, [2] drive_valid,
                                      // [4:3] switch_number, [5] switch_level

  logic [7:0] rx_bytes[$];
  logic [7:0] expected_replies[$];
  logic [7:0] line_buf[0:LINE_CAP-1];
  int         line_fill = 0;
  int         errors = 0;
  int         replies_seen = 0;
  int         burst_left = 1;
  int         gap_left = 0;
  logic [15:0] cyc;
  int         hold_left;
  logic       held;
  logic [7:0] want;

  serial_switch_command_parser dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] char_at(input int i, input int len);
    return (i < len) ? line_buf[i] : CH_NUL;
  endfunction

  function automatic logic [1:0] arg_switch(input int start, input int len);
    int         i;
    int         val;
    bit         neg;
    logic [7:0] c;
    i = start;
    val = 0;
    neg = 1'b0;
    if (char_at(i, len) == CH_NUL) return 2'd0;
    c = char_at(i, len);
    while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      i++;
      c = char_at(i, len);
    end
    if (c == CH_PLUS || c == CH_MINUS) begin
      neg = (c == CH_MINUS);
      i++;
      c = char_at(i, len);
    end
    while (c >= CH_ZERO && c <= CH_NINE) begin
      val = val * 10 + int'(c - CH_ZERO);
      if (val > 3) val = 4;
      i++;
      c = char_at(i, len);
    end
    if (neg || val < 1 || val > 3) return 2'd0;
    return val[1:0];
  endfunction

  // Store a byte, or parse the line on a terminator and queue its reply.
  task automatic absorb_byte(input logic [7:0] b);
    int         len;
    logic [1:0] sw;
    logic       lvl;
    reply_t     code;
    if (b != CH_LF && b != CH_CR) begin
      if (line_fill < LINE_CAP - 1) begin
        line_buf[line_fill] = b;
        line_fill++;
      end else begin
        line_fill = 0;
      end
      return;
    end
    len = 0;
    while (len < line_fill && line_buf[len] != CH_NUL) len++;
    sw = 2'd0;
    lvl = 1'b0;
    code = REPLY_ERR;
    if (len == 3 && char_at(0, len) == CH_V && char_at(1, len) == CH_E &&
        char_at(2, len) == CH_R) begin
      code = REPLY_VER;
    end else if (char_at(0, len) == CH_O && char_at(1, len) == CH_N) begin
      sw = arg_switch(2, len);
      lvl = 1'b1;
    end else if (char_at(0, len) == CH_O && char_at(1, len) == CH_F &&
                 char_at(2, len) == CH_F) begin
      sw = arg_switch(3, len);
    end
    if (code != REPLY_VER) code = (sw != 2'd0) ? REPLY_OK : REPLY_ERR;
    if (sw == 2'd0) lvl = 1'b0;
    expected_replies.push_back({2'b00, lvl, sw, (sw != 2'd0), code});
    line_fill = 0;
  endtask

  task automatic push_text(input string s);
    for (int k = 0; k < s.len(); k++) rx_bytes.push_back(s[k]);
  endtask

  task automatic queue_command();
    int         kind;
    int         n;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      case ($urandom_range(0, 4))
        0, 1: push_text("VER");
        2: push_text("VERR");
        3: begin
          push_text("VER");
          rx_bytes.push_back(CH_NUL);
          push_text("X");
        end
        default: push_text("VE");
      endcase
    end else if (kind < 72) begin
      if ($urandom_range(0, 1)) push_text("ON");
      else push_text("OFF");
      n = $urandom_range(0, 2);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: rx_bytes.push_back(CH_SPACE);
          1: rx_bytes.push_back(CH_TAB);
          2: rx_bytes.push_back(8'h0B);
          default: rx_bytes.push_back(8'h0C);
        endcase
      end
      case ($urandom_range(0, 9))
        0: rx_bytes.push_back(CH_PLUS);
        1: rx_bytes.push_back(CH_MINUS);
        default: ;
      endcase
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) rx_bytes.push_back(CH_ZERO);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : 1;
      repeat (n) begin
        if (n == 1) rx_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 5)));
        else rx_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 9) == 0) rx_bytes.push_back(CH_NUL);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) rx_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end
    end else if (kind < 80) begin
      case ($urandom_range(0, 7))
        0: push_text("O");
        1: push_text("OF");
        2: push_text("ONN1");
        3: push_text("OF1");
        4: push_text("OFFF2");
        5: push_text("on1");
        6: push_text(" ON1");
        default: push_text("XON2");
      endcase
    end else if (kind < 90) begin
      n = $urandom_range(1, 12);
      repeat (n) rx_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 95) begin
      if ($urandom_range(0, 1)) push_text("ON1");
      n = $urandom_range(28, 40);
      repeat (n) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_LF || c == CH_CR) c = CH_SPACE;
        rx_bytes.push_back(c);
      end
    end
    case ($urandom_range(0, 3))
      0: rx_bytes.push_back(CH_CR);
      2: begin
        rx_bytes.push_back(CH_CR);
        rx_bytes.push_back(CH_LF);
      end
      default: rx_bytes.push_back(CH_LF);
    endcase
  endtask

  task automatic compare_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, got_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) absorb_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_bytes.size() != 0) begin
          s_axis_tdata <= rx_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Hold off once for a long stretch so the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      cyc <= '0;
      hold_left <= 0;
      held <= 1'b0;
    end else begin
      cyc <= cyc + 16'd1;
      if (!held && replies_seen >= 20) begin
        held <= 1'b1;
        hold_left <= 300;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        case (cyc[8:7])
          2'd0: m_axis_tready <= 1'b1;
          2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
          2'd2: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= (cyc[2:0] == 3'd0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      replies_seen <= replies_seen + 1;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply: expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        compare_field("reply_code", want[1:0], m_axis_tdata[1:0]);
        compare_field("drive_valid", want[2], m_axis_tdata[2]);
        compare_field("switch_number", want[4:3], m_axis_tdata[4:3]);
        compare_field("switch_level", want[5], m_axis_tdata[5]);
        compare_field("padding", want[7:6], m_axis_tdata[7:6]);
      end
    end
  end

  initial begin
    push_text("VER");
    rx_bytes.push_back(CH_CR);
    rx_bytes.push_back(CH_LF);
    push_text("ON 2");
    rx_bytes.push_back(CH_LF);
    push_text("OFF+3");
    rx_bytes.push_back(CH_CR);
    push_text("ON");
    rx_bytes.push_back(CH_LF);
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    rx_bytes.push_back(CH_LF);
    while (rx_bytes.size() < 600) queue_command();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (rx_bytes.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
